### design/bta_pkg.sv
// Shared constants and types of the board temperature aggregator.
`default_nettype none

package bta_pkg;

   // Table geometry.
   localparam int BOARD_COUNT = 8;
   localparam int IDX_W       = $clog2(BOARD_COUNT);

   // Field widths.
   localparam int TEMP_W = 8;
   localparam int TIME_W = 32;
   localparam int ID_W   = 11;
   localparam int LEN_W  = 4;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 4;
   localparam int SUM_W  = TEMP_W + IDX_W;
   localparam int DIV_CNT_W = $clog2(SUM_W);

   // Frame acceptance and reset values of the registers.
   localparam logic [LEN_W-1:0]  FRAME_LEN    = 4'd4;
   localparam logic [TIME_W-1:0] STALE_RESET  = 32'd1000;
   localparam logic [TIME_W-1:0] GRACE_RESET  = 32'd15000;

   // Temperature limits used as neutral values for min and max.
   localparam logic signed [TEMP_W-1:0] TEMP_HIGHEST = 8'sd127;
   localparam logic signed [TEMP_W-1:0] TEMP_LOWEST  = -8'sd128;

   // Command codes.
   localparam logic CMD_FRAME  = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_ID_BASE  = 2'd0;
   localparam logic [1:0] REG_STALE    = 2'd1;
   localparam logic [1:0] REG_GRACE    = 2'd2;
   localparam logic [1:0] REG_CK_BIAS  = 2'd3;

   // Input transaction.
   typedef struct packed {
      logic                     cmd;
      logic [TIME_W-1:0]        now_ms;
      logic [ID_W-1:0]          frame_id;
      logic [LEN_W-1:0]         frame_len;
      logic [BYTE_W-1:0]        board_byte;
      logic signed [TEMP_W-1:0] min_byte;
      logic signed [TEMP_W-1:0] max_byte;
      logic signed [TEMP_W-1:0] avg_byte;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic signed [TEMP_W-1:0] global_min;
      logic signed [TEMP_W-1:0] global_max;
      logic signed [TEMP_W-1:0] global_avg;
      logic [CNT_W-1:0]         valid_boards;
      logic                     timeout_flag;
      logic [BYTE_W-1:0]        bms_checksum;
   } rsp_type;

   // One table entry as stored in memory.
   typedef struct packed {
      logic signed [TEMP_W-1:0] min_t;
      logic signed [TEMP_W-1:0] max_t;
      logic signed [TEMP_W-1:0] avg_t;
      logic [TIME_W-1:0]        seen_ms;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

### design/bta_channels.sv
// Valid/ready channel interfaces for request and response transactions.
`default_nettype none

interface bta_req_if;
   logic             valid;
   logic             ready;
   bta_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bta_rsp_if;
   logic             valid;
   logic             ready;
   bta_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/bta_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### design/board_temperature_aggregator.sv
// Top level of the board temperature aggregator: table, scan sequencer and divider.
//
//   channel  direction  handshake                      transaction
//   req      in         req.valid / req.ready          frame or report request
//   rsp      out        rsp.valid / rsp.ready          global summary of one report
//   csr      in         APB access, pready tied high   configuration registers
//
// A matching frame writes its board entry on the accept edge; other frames are dropped.
// A report writes the board 0 entry, then reads the table one entry per cycle
// through the memory's read port and divides the average sum one bit per cycle.
// Reset is synchronous and clears the valid marks, control and configuration
// registers; the table memory and datapath registers are not cleared. A stalled
// response holds in its output register while frames keep being accepted;
// a later report waits for that register before finishing.
`default_nettype none

module board_temperature_aggregator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   bta_req_if.sink                             req,
   bta_rsp_if.source                           rsp,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [bta_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [bta_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [bta_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);

   import bta_pkg::*;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BOARD_COUNT - 1);

   // Configuration registers.
   logic [ID_W-1:0]   id_base_ff;
   logic [TIME_W-1:0] stale_ff;
   logic [TIME_W-1:0] grace_ff;
   logic [BYTE_W-1:0] ck_bias_ff;

   // Control state.
   logic [2:0]             state_ff, state_in;
   logic [BOARD_COUNT-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]       issue_idx_ff, issue_idx_in;
   logic                   issuing_ff, issuing_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [TIME_W-1:0]        now_ff, now_in;
   logic signed [TEMP_W-1:0] gmin_ff, gmin_in;
   logic signed [TEMP_W-1:0] gmax_ff, gmax_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     tmo_ff, tmo_in;
   logic [SUM_W-1:0]         div_q_ff, div_q_in;
   logic [CNT_W-1:0]         div_rem_ff, div_rem_in;
   logic                     neg_ff, neg_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   entry_type            ram_wr_data;
   logic                 ram_rd_en;
   logic [ENTRY_W-1:0]   ram_rd_raw;
   entry_type            ram_rd_data;

   logic req_fire;
   logic csr_write;

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_fire   = req.valid && req.ready;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign ram_rd_data = entry_type'(ram_rd_raw);

   // Entry table: min, max, average and last-seen time of every board.
   bta_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (BOARD_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_idx_ff),
      .rd_data (ram_rd_raw)
   );

   // Configuration registers, written by an APB access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         id_base_ff <= '0;
         stale_ff   <= STALE_RESET;
         grace_ff   <= GRACE_RESET;
         ck_bias_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_ID_BASE: id_base_ff <= csr_pwdata[ID_W-1:0];
            REG_STALE:   stale_ff   <= csr_pwdata;
            REG_GRACE:   grace_ff   <= csr_pwdata;
            REG_CK_BIAS: ck_bias_ff <= csr_pwdata[BYTE_W-1:0];
            default:     ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_ID_BASE: csr_prdata = {{(CSR_DATA_W - ID_W){1'b0}}, id_base_ff};
         REG_STALE:   csr_prdata = stale_ff;
         REG_GRACE:   csr_prdata = grace_ff;
         REG_CK_BIAS: csr_prdata = {{(CSR_DATA_W - BYTE_W){1'b0}}, ck_bias_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // Sequencer and datapath next-state logic.
   always_comb begin
      logic [ID_W:0]            id_diff;
      logic                     frame_hit;
      logic [SUM_W-1:0]         sum_mag;
      logic [CNT_W:0]           trial;
      logic [CNT_W:0]           trial_diff;
      logic                     trial_ge;
      logic [SUM_W-1:0]         quot;
      logic signed [TEMP_W-1:0] avg_res;
      logic [TIME_W-1:0]        age;
      logic                     ent_valid;

      state_in     = state_ff;
      valid_in     = valid_ff;
      issue_idx_in = issue_idx_ff;
      issuing_in   = issuing_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = issue_idx_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      now_in       = now_ff;
      gmin_in      = gmin_ff;
      gmax_in      = gmax_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      tmo_in       = tmo_ff;
      div_q_in     = div_q_ff;
      div_rem_in   = div_rem_ff;
      neg_in       = neg_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_rd_en    = 1'b0;

      // Frame acceptance: identifier in window, length four, board byte agrees.
      id_diff   = {1'b0, req.data.frame_id} - {1'b0, id_base_ff};
      frame_hit = !id_diff[ID_W] && (id_diff < (ID_W + 1)'(BOARD_COUNT))
                  && (req.data.frame_len == FRAME_LEN)
                  && ({{(ID_W + 1 - BYTE_W){1'b0}}, req.data.board_byte} == id_diff);

      // A report also stores the time in entry 0; board 0 age is never checked.
      ram_wr_data.min_t   = req.data.min_byte;
      ram_wr_data.max_t   = req.data.max_byte;
      ram_wr_data.avg_t   = req.data.avg_byte;
      ram_wr_data.seen_ms = req.data.now_ms;

      sum_mag    = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
      trial      = {div_rem_ff, div_q_ff[SUM_W-1]};
      trial_diff = trial - {1'b0, cnt_ff};
      trial_ge   = (trial >= {1'b0, cnt_ff});
      quot       = neg_ff ? (~div_q_ff + SUM_W'(1)) : div_q_ff;
      avg_res    = (cnt_ff == '0) ? '0 : TEMP_W'(quot);
      age        = now_ff - ram_rd_data.seen_ms;
      ent_valid  = valid_ff[rd_idx_ff];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.data.cmd == CMD_REPORT) begin
                  ram_wr_en    = 1'b1;
                  ram_wr_addr  = '0;
                  valid_in[0]  = 1'b1;
                  now_in       = req.data.now_ms;
                  gmin_in      = TEMP_HIGHEST;
                  gmax_in      = TEMP_LOWEST;
                  sum_in       = '0;
                  cnt_in       = '0;
                  tmo_in       = 1'b0;
                  issue_idx_in = '0;
                  issuing_in   = 1'b1;
                  state_in     = ST_SCAN;
               end else if (frame_hit) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = id_diff[IDX_W-1:0];
                  valid_in[id_diff[IDX_W-1:0]] = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // Issue one read per cycle; fold each entry in as it returns.
            if (issuing_ff) begin
               ram_rd_en   = 1'b1;
               rd_valid_in = 1'b1;
               if (issue_idx_ff == LAST_IDX) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + IDX_W'(1);
               end
            end
            if (rd_valid_ff) begin
               if (ent_valid) begin
                  if (ram_rd_data.min_t < gmin_ff) begin
                     gmin_in = ram_rd_data.min_t;
                  end
                  if (ram_rd_data.max_t > gmax_ff) begin
                     gmax_in = ram_rd_data.max_t;
                  end
                  sum_in = sum_ff + SUM_W'(ram_rd_data.avg_t);
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (rd_idx_ff != '0) begin
                  if (ent_valid ? (age > stale_ff) : (now_ff > grace_ff)) begin
                     tmo_in = 1'b1;
                  end
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            // Divide the magnitude; the sign is restored at the end.
            div_q_in   = sum_mag;
            div_rem_in = '0;
            neg_in     = sum_ff[SUM_W-1];
            div_cnt_in = DIV_CNT_W'(SUM_W - 1);
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // One restoring division step per cycle.
            div_rem_in = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            div_q_in   = {div_q_ff[SUM_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Wait for the output register to free up, then publish.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_data_in.global_min   = gmin_ff;
               rsp_data_in.global_max   = gmax_ff;
               rsp_data_in.global_avg   = avg_res;
               rsp_data_in.valid_boards = cnt_ff;
               rsp_data_in.timeout_flag = tmo_ff;
               rsp_data_in.bms_checksum = BYTE_W'(gmin_ff) + BYTE_W'(gmax_ff)
                                          + BYTE_W'(avg_res) + ck_bias_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         issue_idx_ff <= '0;
         issuing_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rd_idx_ff    <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         issue_idx_ff <= issue_idx_in;
         issuing_ff   <= issuing_in;
         rd_valid_ff  <= rd_valid_in;
         rd_idx_ff    <= rd_idx_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      gmin_ff     <= gmin_in;
      gmax_ff     <= gmax_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      tmo_ff      <= tmo_in;
      div_q_ff    <= div_q_in;
      div_rem_ff  <= div_rem_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // A report always counts board 0, so a published summary has a valid board.
   a_rsp_has_board: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.valid_boards != '0))
      else $error("response published with no valid board");

   // Board 0 is marked valid right after a report is accepted.
   a_report_marks_local: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req.data.cmd == CMD_REPORT)) |=> valid_ff[0])
      else $error("report did not mark board 0 valid");

   // No table read is in flight outside the scan.
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN))
      else $error("table read outside scan");

   // The divider finishes into the publish state.
   a_div_to_fin: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && (div_cnt_ff == '0)) |=> (state_ff == ST_FIN))
      else $error("divider did not hand over to publish");
`endif

endmodule

`default_nettype wire
